// ----- src/trickle_timer_unit_defines.svh -----
// assertion macros for the checker file
`ifndef TRICKLE_TIMER_UNIT_DEFINES_SVH
`define TRICKLE_TIMER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TT_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TT_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tt_pkg.sv -----
package tt_pkg;

  localparam int RAND_W      = 31;
  localparam int INTV_W      = 32;
  localparam int CNT_W       = 16;
  localparam int EXP_W       = 5;
  localparam int K_W         = 8;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [INTV_W-1:0] INTV_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [EXP_W-1:0] IMIN_EXP_RST  = 5'd3;
  localparam logic [EXP_W-1:0] DOUBLINGS_RST = 5'd20;
  localparam logic [K_W-1:0]   K_RST         = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_HEARD = 2'd1,
    CMD_RESET = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMIN_EXP     = 2'd0,
    REG_DOUBLINGS    = 2'd1,
    REG_REDUNDANCY_K = 2'd2
  } reg_idx_t;

endpackage

// ----- src/trickle_timer_unit.sv -----
// channel  | direction | tdata                                   | tuser
// in_      | slave     | [30:0] rand_word, [31] zero             | [1:0] cmd
// out_     | master    | [0] transmit, [1] new_interval,         | -
//          |           | [33:2] interval_now, [39:34] zero       |
// cfg_     | write     | cfg_data [7:0], index in cfg_index      | -
//
// an item that starts no new interval goes from exec straight to done
// an item that starts a new interval goes through load, div and fin to done;
// in div the serial remainder unit draws the firing point, one bit per cycle
// one item is in work at a time; the next is accepted once the result is
// registered, even if the output side is still stalled
// reset is synchronous active low and leaves the timer idle until a start

module trickle_timer_unit import tt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] rand_word, [31] zero
  input  logic [CMD_W-1:0]       in_tuser,   // [1:0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] transmit, [1] new_interval,
                                             // [33:2] interval_now, [39:34] zero
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t                 state_r;
  cmd_t                   cmd_r;
  logic [RAND_W-1:0]      rand_r;
  logic [EXP_W-1:0]       imin_exp_r;
  logic [EXP_W-1:0]       doublings_r;
  logic [K_W-1:0]         k_r;
  logic [INTV_W-1:0]      intv_r;
  logic [INTV_W-1:0]      fire_r;
  logic [INTV_W-1:0]      elapsed_r;
  logic [CNT_W-1:0]       count_r;
  logic                   running_r;
  logic                   tx_r;
  logic                   fresh_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [INTV_W-1:0] imin;
  logic [5:0]        mask_sh;
  logic [RAND_W-1:0] rmask;
  logic [INTV_W:0]   start_sum;
  logic [INTV_W-1:0] start_len;
  logic [5:0]        cap_sh;
  logic [INTV_W-1:0] cap;
  logic [INTV_W:0]   dbl;
  logic [INTV_W-1:0] dbl_len;
  logic [INTV_W-1:0] elapsed_inc;
  logic [INTV_W-1:0] target;
  logic              tx_ok;
  logic [INTV_W-1:0] half;
  logic [INTV_W-1:0] span;
  logic              div_start;
  logic              div_done;
  logic [INTV_W-1:0] div_rem;
  logic              new_intv;
  logic              out_load;

  assign imin = INTV_W'(1) << imin_exp_r;

  // rand mod 4*imin is a mask, as 4*imin is a power of two
  assign mask_sh   = {1'b0, imin_exp_r} + 6'd2;
  assign rmask     = ~({RAND_W{1'b1}} << mask_sh);
  assign start_sum = {1'b0, imin} + {2'b00, rand_r & rmask};
  assign start_len = start_sum[INTV_W] ? INTV_MAX : start_sum[INTV_W-1:0];

  assign cap_sh  = {1'b0, imin_exp_r} + {1'b0, doublings_r};
  assign cap     = cap_sh[5] ? INTV_MAX : (INTV_W'(1) << cap_sh[4:0]);
  assign dbl     = {intv_r, 1'b0};
  assign dbl_len = (dbl > {1'b0, cap} || dbl == '0) ? cap : dbl[INTV_W-1:0];

  assign elapsed_inc = (elapsed_r == INTV_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign target      = (fire_r == '0) ? INTV_W'(1) : fire_r;
  assign tx_ok       = (k_r == '0) || (count_r < {{(CNT_W-K_W){1'b0}}, k_r});

  // span is ceil(I/2) + 1
  assign half = {1'b0, intv_r[INTV_W-1:1]};
  assign span = half + {{(INTV_W-1){1'b0}}, intv_r[0]} + INTV_W'(1);

  // the executed command opens a new interval
  assign new_intv = (cmd_r == CMD_START) ||
                    (running_r && cmd_r == CMD_RESET) ||
                    (running_r && cmd_r == CMD_TICK && elapsed_inc >= intv_r);

  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  assign div_start = (state_r == ST_LOAD);

  tt_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rand_r),
    .divisor  (span),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      imin_exp_r   <= IMIN_EXP_RST;
      doublings_r  <= DOUBLINGS_RST;
      k_r          <= K_RST;
      intv_r       <= '0;
      fire_r       <= '0;
      elapsed_r    <= '0;
      count_r      <= '0;
      running_r    <= 1'b0;
      tx_r         <= 1'b0;
      fresh_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IMIN_EXP:     imin_exp_r  <= cfg_data[EXP_W-1:0];
          REG_DOUBLINGS:    doublings_r <= cfg_data[EXP_W-1:0];
          REG_REDUNDANCY_K: k_r         <= cfg_data[K_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= cmd_t'(in_tuser);
            rand_r  <= in_tdata[RAND_W-1:0];
            tx_r    <= 1'b0;
            fresh_r <= 1'b0;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= new_intv ? ST_LOAD : ST_DONE;
          case (cmd_r)
            CMD_START: begin
              intv_r    <= start_len;
              running_r <= 1'b1;
              fresh_r   <= 1'b1;
            end
            CMD_RESET: begin
              if (running_r) begin
                intv_r  <= imin;
                fresh_r <= 1'b1;
              end
            end
            CMD_HEARD: begin
              if (running_r && count_r != CNT_MAX) begin
                count_r <= count_r + 1'b1;
              end
            end
            default: begin
              // tick: firing check uses the count as it stands
              if (running_r) begin
                elapsed_r <= elapsed_inc;
                tx_r      <= (elapsed_inc == target) && tx_ok;
                if (elapsed_inc >= intv_r) begin
                  intv_r  <= dbl_len;
                  fresh_r <= 1'b1;
                end
              end
            end
          endcase
        end
        ST_LOAD: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          fire_r    <= half + div_rem;
          count_r   <= '0;
          elapsed_r <= '0;
          state_r   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_tdata_r  <= {{(OUT_TDATA_W-INTV_W-2){1'b0}},
                             running_r ? intv_r : INTV_W'(0), fresh_r, tx_r};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- src/tt_mod.sv -----
// bit-serial restoring remainder: one dividend bit shifted in per cycle
module tt_mod import tt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [INTV_W-1:0] divisor,
  output logic              done,
  output logic [INTV_W-1:0] rem
);

  localparam int CNT_BITS = $clog2(RAND_W);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(RAND_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [RAND_W-1:0]   quo_r;
  logic [INTV_W-1:0]   div_r;
  logic [INTV_W-1:0]   rem_r;

  logic [INTV_W:0]     sh;
  logic                ge;
  logic [INTV_W-1:0]   rem_nxt;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign sh      = {rem_r, quo_r[RAND_W-1]};
  assign ge      = sh >= {1'b0, div_r};
  assign rem_nxt = ge ? INTV_W'(sh - {1'b0, div_r}) : sh[INTV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[RAND_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- src/tt_checker.sv -----
`include "trickle_timer_unit_defines.svh"

module tt_checker import tt_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `TT_AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `TT_AST_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "second transaction taken while busy")
  `TT_AST_NOW(a_fresh_len, out_tvalid && out_tdata[1], out_tdata[33:2] != '0, "new interval with zero length")
  `TT_AST_NOW(a_tx_len, out_tvalid && out_tdata[0], out_tdata[33:2] != '0, "transmit while idle")

endmodule

bind trickle_timer_unit tt_checker u_tt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/tb.sv -----
module tb;
  import tt_pkg::*;

  typedef struct packed {
    logic              tx;
    logic              fresh;
    logic [INTV_W-1:0] intv;
  } result_t;

  typedef struct {
    bit                is_cfg;
    cmd_t              cmd;
    logic [RAND_W-1:0] word;
    logic [EXP_W-1:0]  imin;
    logic [EXP_W-1:0]  dbl;
    logic [K_W-1:0]    k;
    bit                typed;
    result_t           want;
  } script_row_t;

  localparam int    HEARD_RUN   = 20;
  localparam int    PHASES      = 16;
  localparam int    PHASE_ITEMS = 100;
  localparam int    SETTLE      = 40;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [30:0] rand_word, [31] zero
  logic [CMD_W-1:0]       in_tuser = '0;   // [1:0] cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] transmit, [1] new_interval,
                                           // [33:2] interval_now, [39:34] zero
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  trickle_timer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // timer predictor state
  logic [EXP_W-1:0]  p_imin_exp  = IMIN_EXP_RST;
  logic [EXP_W-1:0]  p_doublings = DOUBLINGS_RST;
  logic [K_W-1:0]    p_k         = K_RST;
  logic [INTV_W-1:0] p_intv      = '0;
  logic [INTV_W-1:0] p_fire      = '0;
  logic [INTV_W-1:0] p_elapsed   = '0;
  logic [CNT_W-1:0]  p_heard     = '0;
  logic              p_running   = 1'b0;

  result_t     pending_results[$];
  script_row_t script[$];
  int          fail_count = 0;
  longint      cycles = 0;
  bit          idle_on = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void draw_fire(logic [RAND_W-1:0] r);
    logic [63:0] half;
    logic [63:0] span;
    half = {32'd0, p_intv} >> 1;
    span = {32'd0, p_intv} - half + 64'd1;
    p_fire = INTV_W'(half + 64'(r) % span);
    p_heard = '0;
    p_elapsed = '0;
  endfunction

  function automatic result_t trickle_step(cmd_t c, logic [RAND_W-1:0] r);
    logic [63:0]       imin;
    logic [63:0]       cap;
    logic [63:0]       len;
    logic [63:0]       dbl;
    logic [INTV_W-1:0] target;
    result_t           res;
    imin = 64'd1 << p_imin_exp;
    cap = imin << p_doublings;
    if (cap > SAT32) cap = SAT32;
    res = '0;
    if (c == CMD_START) begin
      len = imin + 64'(r) % (imin * 4);
      if (len > SAT32) len = SAT32;
      p_intv = len[INTV_W-1:0];
      p_running = 1'b1;
      draw_fire(r);
      res.fresh = 1'b1;
    end else if (p_running) begin
      case (c)
        CMD_RESET: begin
          p_intv = imin[INTV_W-1:0];
          draw_fire(r);
          res.fresh = 1'b1;
        end
        CMD_HEARD: begin
          if (p_heard != CNT_MAX) p_heard = p_heard + 1'b1;
        end
        default: begin
          // a firing point of zero fires on the first tick
          target = (p_fire == '0) ? INTV_W'(1) : p_fire;
          if (p_elapsed != INTV_MAX) p_elapsed = p_elapsed + 1'b1;
          if (p_elapsed == target && (p_k == '0 || p_heard < p_k)) res.tx = 1'b1;
          if (p_elapsed >= p_intv) begin
            dbl = {32'd0, p_intv} * 2;
            if (dbl > cap) dbl = cap;
            if (dbl == 64'd0) dbl = cap;
            p_intv = dbl[INTV_W-1:0];
            draw_fire(r);
            res.fresh = 1'b1;
          end
        end
      endcase
    end
    res.intv = p_running ? p_intv : '0;
    return res;
  endfunction

  function automatic void add_item(cmd_t c, logic [RAND_W-1:0] w, bit typed, result_t want);
    script_row_t row;
    row = '{is_cfg: 1'b0, cmd: c, word: w, imin: '0, dbl: '0, k: '0,
            typed: typed, want: want};
    script.push_back(row);
  endfunction

  function automatic void add_cfg(logic [EXP_W-1:0] e, logic [EXP_W-1:0] d,
                                  logic [K_W-1:0] k);
    script_row_t row;
    row = '{is_cfg: 1'b1, cmd: CMD_TICK, word: '0, imin: e, dbl: d, k: k,
            typed: 1'b0, want: '0};
    script.push_back(row);
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic set_config(logic [EXP_W-1:0] e, logic [EXP_W-1:0] d, logic [K_W-1:0] k);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_IMIN_EXP;
    cfg_data  <= CFG_DATA_W'(e);
    @(posedge clk);
    cfg_index <= REG_DOUBLINGS;
    cfg_data  <= CFG_DATA_W'(d);
    @(posedge clk);
    cfg_index <= REG_REDUNDANCY_K;
    cfg_data  <= CFG_DATA_W'(k);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_imin_exp = e;
    p_doublings = d;
    p_k = k;
  endtask

  task automatic push_item(cmd_t c, logic [RAND_W-1:0] r, bit typed, result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {{(IN_TDATA_W-RAND_W){1'b0}}, r};
    do @(posedge clk); while (!in_tready);
    predicted = trickle_step(c, r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: out_tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.tx) begin
          $error("transmit: expected %0d, got %0d", want.tx, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== want.fresh) begin
          $error("new_interval: expected %0d, got %0d", want.fresh, out_tdata[1]);
          fail_count++;
        end
        if (out_tdata[33:2] !== want.intv) begin
          $error("interval_now: expected %0d, got %0d", want.intv, out_tdata[33:2]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [EXP_W-1:0]  e;
    logic [EXP_W-1:0]  d;
    logic [K_W-1:0]    k;
    logic [RAND_W-1:0] w;
    cmd_t              c;
    int                pick;

    // idle timer ignores everything but start
    add_item(CMD_TICK,  31'h0,        1, {1'b0, 1'b0, 32'd0});
    add_item(CMD_HEARD, 31'h7fffffff, 1, {1'b0, 1'b0, 32'd0});
    add_item(CMD_RESET, 31'h7fffffff, 1, {1'b0, 1'b0, 32'd0});
    add_item(CMD_START, 31'h0,        1, {1'b0, 1'b1, 32'd8});
    add_item(CMD_HEARD, 31'h0,        0, '0);
    repeat (7) add_item(CMD_TICK, 31'h0, 0, '0);
    add_item(CMD_TICK,  31'h7fffffff, 0, '0);
    // restart while running
    add_item(CMD_START, 31'h7fffffff, 1, {1'b0, 1'b1, 32'd39});
    add_item(CMD_RESET, 31'h2aaaaaaa, 1, {1'b0, 1'b1, 32'd8});
    // interval of one tick with firing point zero, always transmit
    add_cfg(5'd0, 5'd0, 8'd0);
    add_item(CMD_RESET, 31'h0,        1, {1'b0, 1'b1, 32'd1});
    add_item(CMD_TICK,  31'h0,        1, {1'b1, 1'b1, 32'd1});
    add_item(CMD_TICK,  31'h1,        0, '0);
    // largest minimum, saturated cap
    add_cfg(5'd31, 5'd31, 8'd255);
    add_item(CMD_START, 31'h7fffffff, 1, {1'b0, 1'b1, 32'hffffffff});
    add_item(CMD_RESET, 31'h0,        1, {1'b0, 1'b1, 32'h80000000});
    add_item(CMD_HEARD, 31'h5555_5555, 0, '0);
    add_item(CMD_TICK,  31'h7fffffff, 0, '0);
    add_cfg(5'd30, 5'd31, 8'd1);
    add_item(CMD_START, 31'h7fffffff, 1, {1'b0, 1'b1, 32'hbfffffff});
    add_item(CMD_TICK,  31'h0,        0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) set_config(script[i].imin, script[i].dbl, script[i].k);
      else push_item(script[i].cmd, script[i].word, script[i].typed, script[i].want);
    end

    // more heard messages than k keep the firing point silent
    idle_on = 1'b0;
    set_config(5'd0, 5'd2, 8'd16);
    push_item(CMD_START, 31'd3, 1, {1'b0, 1'b1, 32'd4});
    repeat (HEARD_RUN) push_item(CMD_HEARD, RAND_W'($urandom), 0, '0);
    repeat (6) push_item(CMD_TICK, RAND_W'($urandom), 0, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin e = 5'd0;  d = 5'd0;  k = 8'd0;   end
        1: begin e = 5'd0;  d = 5'd31; k = 8'd255; end
        2: begin e = 5'd31; d = 5'd31; k = 8'd1;   end
        3: begin e = 5'd30; d = 5'd0;  k = 8'd0;   end
        4: begin e = 5'd1;  d = 5'd1;  k = 8'd255; end
        default: begin
          e = ($urandom_range(0, 7) == 0) ? EXP_W'($urandom_range(0, 31))
                                          : EXP_W'($urandom_range(0, 4));
          d = ($urandom_range(0, 3) == 0) ? EXP_W'($urandom_range(0, 31))
                                          : EXP_W'($urandom_range(0, 6));
          pick = $urandom_range(0, 3);
          k = (pick == 0) ? K_W'(0) :
              (pick == 3) ? K_W'($urandom_range(0, 255)) : K_W'($urandom_range(1, 4));
        end
      endcase
      set_config(e, d, k);
      // the closing stretch runs without any idling
      idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      push_item(CMD_START, RAND_W'($urandom), 0, '0);
      repeat (PHASE_ITEMS - 1) begin
        pick = $urandom_range(0, 99);
        c = (pick < 70) ? CMD_TICK : (pick < 85) ? CMD_HEARD :
            (pick < 93) ? CMD_RESET : CMD_START;
        w = ($urandom_range(0, 3) == 0) ? RAND_W'($urandom_range(0, 7)) : RAND_W'($urandom);
        push_item(c, w, 0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
